>>> rtl/flpl_pkg.sv
// ----------------------------------------------------------------------------
// flpl_pkg
// Shared types and constants of the FIFO lot position ledger.
// ----------------------------------------------------------------------------
package flpl_pkg;

   localparam int QTY_W   = 32;
   localparam int PRICE_W = 32;
   localparam int CFG_W   = 30;
   localparam int CSR_W   = 2;
   localparam int VAL_W   = 63;
   localparam int ACC_W   = 64;

   localparam logic [CFG_W-1:0] PRICE_SCALE_RESET = CFG_W'(100000);

   typedef enum logic [CSR_W-1:0] {
      CSR_PRICE_SCALE      = 2'd0,
      CSR_FEE_PER_SHARE    = 2'd1,
      CSR_REBATE_PER_SHARE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BADQTY = 2'd1,
      STAT_OVF    = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      MUL_UNIT,
      MUL_TV,
      MUL_FEE,
      MUL_REB,
      MUL_LOT
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHKQ,
      ST_MLOAD,
      ST_MLO,
      ST_MHI,
      ST_MSUM,
      ST_MFIN,
      ST_SUMS,
      ST_WALK_RD,
      ST_WALK_EVAL,
      ST_LOTADD,
      ST_FULLCHK,
      ST_COMMIT,
      ST_PUSH,
      ST_REPLY
   } fsm_state_type;

   typedef struct packed {
      logic              is_sell;
      logic [QTY_W-1:0]  shares;
      logic [ACC_W-1:0]  cost;
   } lot_type;

   typedef struct packed {
      logic       capture;
      logic       init;
      logic       mul_load;
      mul_op_type mul_op;
      logic       mul_lo;
      logic       mul_hi;
      logic       mul_sum;
      logic       mul_fin;
      logic       sums;
      logic       lot_rd;
      logic       lot_eval;
      logic       lot_add;
      logic       commit;
      logic       push;
      logic       out_load;
      status_type out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic qty_zero;
      logic mul_ovf;
      logic sums_ovf;
      logic walk_done;
      logic same_side;
      logic lot_ovf;
      logic ring_full;
      logic real_ovf;
      logic rem_zero;
      logic out_free;
   } dp_sts_type;

endpackage

>>> rtl/flpl_if.sv
// ----------------------------------------------------------------------------
// flpl_req_if / flpl_rsp_if
// Valid/ready channels for fill words and result words.
// ----------------------------------------------------------------------------
interface flpl_req_if;
   logic        valid;
   logic        ready;
   logic        side;
   logic [31:0] fill_quantity;
   logic [31:0] fill_price;

   modport source (output valid, side, fill_quantity, fill_price, input ready);
   modport sink   (input valid, side, fill_quantity, fill_price, output ready);
endinterface

interface flpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [62:0] notional_value;
   logic [62:0] fee_amount;
   logic [62:0] rebate_amount;
   logic signed [63:0] realized_change;

   modport source (output valid, status, notional_value, fee_amount, rebate_amount,
                   realized_change, input ready);
   modport sink   (input valid, status, notional_value, fee_amount, rebate_amount,
                   realized_change, output ready);
endinterface

>>> rtl/flpl_ram.sv
// ----------------------------------------------------------------------------
// flpl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/flpl_ctrl.sv
// ----------------------------------------------------------------------------
// flpl_ctrl
// Sequencer: runs the checks, the shared multiplier and the lot walk.
// ----------------------------------------------------------------------------
module flpl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  flpl_pkg::dp_sts_type   sts,
   output flpl_pkg::dp_cmd_type   cmd
);
   flpl_pkg::fsm_state_type state_ff, state_in;
   flpl_pkg::mul_op_type    op_ff, op_in;
   flpl_pkg::status_type    status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= flpl_pkg::ST_IDLE;
         op_ff     <= flpl_pkg::MUL_UNIT;
         status_ff <= flpl_pkg::STAT_OK;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      status_in      = status_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.mul_op     = op_ff;
      cmd.out_status = status_ff;
      unique case (state_ff)
         flpl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               status_in   = flpl_pkg::STAT_OK;
               state_in    = flpl_pkg::ST_CHKQ;
            end
         end
         flpl_pkg::ST_CHKQ: begin
            if (sts.qty_zero) begin
               status_in = flpl_pkg::STAT_BADQTY;
               state_in  = flpl_pkg::ST_REPLY;
            end else begin
               cmd.init = 1'b1;
               op_in    = flpl_pkg::MUL_UNIT;
               state_in = flpl_pkg::ST_MLOAD;
            end
         end
         flpl_pkg::ST_MLOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = flpl_pkg::ST_MLO;
         end
         flpl_pkg::ST_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = flpl_pkg::ST_MHI;
         end
         flpl_pkg::ST_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = flpl_pkg::ST_MSUM;
         end
         flpl_pkg::ST_MSUM: begin
            cmd.mul_sum = 1'b1;
            state_in    = flpl_pkg::ST_MFIN;
         end
         flpl_pkg::ST_MFIN: begin
            cmd.mul_fin = 1'b1;
            if (sts.mul_ovf) begin
               status_in = flpl_pkg::STAT_OVF;
               state_in  = flpl_pkg::ST_REPLY;
            end else begin
               unique case (op_ff)
                  flpl_pkg::MUL_UNIT: begin
                     op_in    = flpl_pkg::MUL_TV;
                     state_in = flpl_pkg::ST_MLOAD;
                  end
                  flpl_pkg::MUL_TV: begin
                     op_in    = flpl_pkg::MUL_FEE;
                     state_in = flpl_pkg::ST_MLOAD;
                  end
                  flpl_pkg::MUL_FEE: begin
                     op_in    = flpl_pkg::MUL_REB;
                     state_in = flpl_pkg::ST_MLOAD;
                  end
                  flpl_pkg::MUL_REB: state_in = flpl_pkg::ST_SUMS;
                  flpl_pkg::MUL_LOT: state_in = flpl_pkg::ST_LOTADD;
                  default:           state_in = flpl_pkg::ST_IDLE;
               endcase
            end
         end
         flpl_pkg::ST_SUMS: begin
            cmd.sums = 1'b1;
            if (sts.sums_ovf) begin
               status_in = flpl_pkg::STAT_OVF;
               state_in  = flpl_pkg::ST_REPLY;
            end else begin
               state_in = flpl_pkg::ST_WALK_RD;
            end
         end
         flpl_pkg::ST_WALK_RD: begin
            if (sts.walk_done) begin
               state_in = flpl_pkg::ST_FULLCHK;
            end else begin
               cmd.lot_rd = 1'b1;
               state_in   = flpl_pkg::ST_WALK_EVAL;
            end
         end
         flpl_pkg::ST_WALK_EVAL: begin
            if (sts.same_side) begin
               state_in = flpl_pkg::ST_FULLCHK;
            end else begin
               cmd.lot_eval = 1'b1;
               op_in        = flpl_pkg::MUL_LOT;
               state_in     = flpl_pkg::ST_MLOAD;
            end
         end
         flpl_pkg::ST_LOTADD: begin
            cmd.lot_add = 1'b1;
            if (sts.lot_ovf) begin
               status_in = flpl_pkg::STAT_OVF;
               state_in  = flpl_pkg::ST_REPLY;
            end else begin
               state_in = flpl_pkg::ST_WALK_RD;
            end
         end
         flpl_pkg::ST_FULLCHK: begin
            priority if (sts.ring_full) begin
               status_in = flpl_pkg::STAT_FULL;
               state_in  = flpl_pkg::ST_REPLY;
            end else if (sts.real_ovf) begin
               status_in = flpl_pkg::STAT_OVF;
               state_in  = flpl_pkg::ST_REPLY;
            end else begin
               state_in = flpl_pkg::ST_COMMIT;
            end
         end
         flpl_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.rem_zero ? flpl_pkg::ST_REPLY : flpl_pkg::ST_PUSH;
         end
         flpl_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = flpl_pkg::ST_REPLY;
         end
         flpl_pkg::ST_REPLY: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = flpl_pkg::ST_IDLE;
            end
         end
         default: state_in = flpl_pkg::ST_IDLE;
      endcase
   end
endmodule

>>> rtl/flpl_dpath.sv
// ----------------------------------------------------------------------------
// flpl_dpath
// Ledger datapath: settings, totals, shared 64x32 multiplier, lot ring.
// ----------------------------------------------------------------------------
module flpl_dpath #(
   parameter int LOT_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  flpl_pkg::dp_cmd_type   cmd,
   output flpl_pkg::dp_sts_type   sts,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [29:0]            csr_wdata,
   input  logic                   req_side,
   input  logic [31:0]            req_quantity,
   input  logic [31:0]            req_price,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [62:0]            rsp_notional_value,
   output logic [62:0]            rsp_fee_amount,
   output logic [62:0]            rsp_rebate_amount,
   output logic signed [63:0]     rsp_realized_change
);
   localparam int AW = (LOT_DEPTH > 1) ? $clog2(LOT_DEPTH) : 1;
   localparam int CW = $clog2(LOT_DEPTH + 1);
   localparam logic [CW:0]   WRAP_DEPTH = (CW + 1)'(LOT_DEPTH);
   localparam logic [CW-1:0] CNT_DEPTH  = CW'(LOT_DEPTH);
   localparam logic [63:0]   POS_LIM    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]   NEG_LIM    = 64'h8000_0000_0000_0000;

   function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
      logic [CW:0] t;
      t = (s >= WRAP_DEPTH) ? s - WRAP_DEPTH : s;
      return t[AW-1:0];
   endfunction

   function automatic logic add_ovf(input logic [63:0] a, b, s);
      return (a[63] == b[63]) && (s[63] != a[63]);
   endfunction

   logic [29:0] scale_ff, scale_in, fee_ff, fee_in, reb_ff, reb_in;
   logic        sell_ff, sell_in;
   logic [31:0] qty_ff, qty_in, price_ff, price_in;
   logic [63:0] unit_ff, unit_in, tv_ff, tv_in, fe_ff, fe_in, rb_ff, rb_in;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [31:0] q_ff, q_in;
   logic [63:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [95:0] full_ff, full_in;
   logic [63:0] piece_ff, piece_in;
   logic [63:0] pos_ff, pos_in, cash_ff, cash_in, feet_ff, feet_in;
   logic [63:0] rebt_ff, rebt_in, realt_ff, realt_in, vol_ff, vol_in;
   logic [63:0] npos_ff, npos_in, ncash_ff, ncash_in, nfee_ff, nfee_in;
   logic [63:0] nreb_ff, nreb_in;
   logic [31:0] rem_ff, rem_in, left_ff, left_in, closed_ff, closed_in;
   logic [CW-1:0] popped_ff, popped_in, count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [63:0] realized_ff, realized_in, per_ff, per_in;
   logic        partial_ff, partial_in;
   flpl_pkg::lot_type lot_ff, lot_in, lot_rd, wr_lot;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [62:0] rsp_tv_ff, rsp_tv_in, rsp_fe_ff, rsp_fe_in, rsp_rb_ff, rsp_rb_in;
   logic [63:0] rsp_rz_ff, rsp_rz_in;

   logic [63:0] mul_v, mul_res, lim;
   logic [31:0] mul_q;
   logic [63:0] sq, cash_add, sum_pos, sum_cash, sum_fee, sum_reb, sum_real, sum_lot;
   logic [64:0] sum_vol;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [$bits(flpl_pkg::lot_type)-1:0] rd_data;

   assign lot_rd = flpl_pkg::lot_type'(rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= flpl_pkg::PRICE_SCALE_RESET;
         fee_ff       <= '0;
         reb_ff       <= '0;
         pos_ff       <= '0;
         cash_ff      <= '0;
         feet_ff      <= '0;
         rebt_ff      <= '0;
         realt_ff     <= '0;
         vol_ff       <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         fee_ff       <= fee_in;
         reb_ff       <= reb_in;
         pos_ff       <= pos_in;
         cash_ff      <= cash_in;
         feet_ff      <= feet_in;
         rebt_ff      <= rebt_in;
         realt_ff     <= realt_in;
         vol_ff       <= vol_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sell_ff       <= sell_in;
      qty_ff        <= qty_in;
      price_ff      <= price_in;
      unit_ff       <= unit_in;
      tv_ff         <= tv_in;
      fe_ff         <= fe_in;
      rb_ff         <= rb_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      q_ff          <= q_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      full_ff       <= full_in;
      piece_ff      <= piece_in;
      npos_ff       <= npos_in;
      ncash_ff      <= ncash_in;
      nfee_ff       <= nfee_in;
      nreb_ff       <= nreb_in;
      rem_ff        <= rem_in;
      left_ff       <= left_in;
      closed_ff     <= closed_in;
      popped_ff     <= popped_in;
      realized_ff   <= realized_in;
      per_ff        <= per_in;
      partial_ff    <= partial_in;
      lot_ff        <= lot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tv_ff     <= rsp_tv_in;
      rsp_fe_ff     <= rsp_fe_in;
      rsp_rb_ff     <= rsp_rb_in;
      rsp_rz_ff     <= rsp_rz_in;
   end

   always_comb begin
      unique case (cmd.mul_op)
         flpl_pkg::MUL_UNIT: begin mul_v = 64'(scale_ff); mul_q = price_ff;  end
         flpl_pkg::MUL_TV:   begin mul_v = unit_ff;       mul_q = qty_ff;    end
         flpl_pkg::MUL_FEE:  begin mul_v = 64'(fee_ff);   mul_q = qty_ff;    end
         flpl_pkg::MUL_REB:  begin mul_v = 64'(reb_ff);   mul_q = qty_ff;    end
         flpl_pkg::MUL_LOT:  begin mul_v = per_ff;        mul_q = closed_ff; end
         default:            begin mul_v = '0;            mul_q = '0;        end
      endcase
   end

   assign lim     = neg_ff ? NEG_LIM : POS_LIM;
   assign mul_res = neg_ff ? -full_ff[63:0] : full_ff[63:0];

   assign sq       = sell_ff ? -{32'd0, qty_ff} : {32'd0, qty_ff};
   assign cash_add = sell_ff ? tv_ff : -tv_ff;
   assign sum_pos  = pos_ff + sq;
   assign sum_cash = cash_ff + cash_add;
   assign sum_fee  = feet_ff + fe_ff;
   assign sum_reb  = rebt_ff + rb_ff;
   assign sum_vol  = {1'b0, vol_ff} + 65'(qty_ff);
   assign sum_real = realt_ff + realized_ff;
   assign sum_lot  = realized_ff + piece_ff;

   always_comb begin
      scale_in = scale_ff;
      fee_in   = fee_ff;
      reb_in   = reb_ff;
      if (csr_we) begin
         case (csr_index)
            flpl_pkg::CSR_PRICE_SCALE:      scale_in = csr_wdata;
            flpl_pkg::CSR_FEE_PER_SHARE:    fee_in   = csr_wdata;
            flpl_pkg::CSR_REBATE_PER_SHARE: reb_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sell_in     = sell_ff;
      qty_in      = qty_ff;
      price_in    = price_ff;
      unit_in     = unit_ff;
      tv_in       = tv_ff;
      fe_in       = fe_ff;
      rb_in       = rb_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      q_in        = q_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      full_in     = full_ff;
      piece_in    = piece_ff;
      pos_in      = pos_ff;
      cash_in     = cash_ff;
      feet_in     = feet_ff;
      rebt_in     = rebt_ff;
      realt_in    = realt_ff;
      vol_in      = vol_ff;
      npos_in     = npos_ff;
      ncash_in    = ncash_ff;
      nfee_in     = nfee_ff;
      nreb_in     = nreb_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      closed_in   = closed_ff;
      popped_in   = popped_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      realized_in = realized_ff;
      per_in      = per_ff;
      partial_in  = partial_ff;
      lot_in      = lot_ff;
      wr_en       = 1'b0;
      wr_addr     = wrap_idx((CW + 1)'(head_ff) + (CW + 1)'(popped_ff));
      wr_lot      = {lot_ff.is_sell, left_ff, lot_ff.cost};
      rd_addr     = wrap_idx((CW + 1)'(head_ff) + (CW + 1)'(popped_ff));

      if (cmd.capture) begin
         sell_in  = req_side;
         qty_in   = req_quantity;
         price_in = req_price;
      end
      if (cmd.init) begin
         rem_in      = qty_ff;
         popped_in   = '0;
         realized_in = '0;
         partial_in  = 1'b0;
      end
      if (cmd.mul_load) begin
         neg_in = mul_v[63];
         mag_in = mul_v[63] ? -mul_v : mul_v;
         q_in   = mul_q;
      end
      if (cmd.mul_lo) begin
         plo_in = 64'(mag_ff[31:0]) * 64'(q_ff);
      end
      if (cmd.mul_hi) begin
         phi_in = 64'(mag_ff[63:32]) * 64'(q_ff);
      end
      if (cmd.mul_sum) begin
         full_in = {phi_ff, 32'd0} + {32'd0, plo_ff};
      end
      if (cmd.mul_fin) begin
         unique case (cmd.mul_op)
            flpl_pkg::MUL_UNIT: unit_in  = mul_res;
            flpl_pkg::MUL_TV:   tv_in    = mul_res;
            flpl_pkg::MUL_FEE:  fe_in    = mul_res;
            flpl_pkg::MUL_REB:  rb_in    = mul_res;
            flpl_pkg::MUL_LOT:  piece_in = mul_res;
            default: ;
         endcase
      end
      if (cmd.sums) begin
         npos_in  = sum_pos;
         ncash_in = sum_cash;
         nfee_in  = sum_fee;
         nreb_in  = sum_reb;
      end
      if (cmd.lot_eval) begin
         lot_in    = lot_rd;
         closed_in = (rem_ff < lot_rd.shares) ? rem_ff : lot_rd.shares;
         per_in    = sell_ff ? unit_ff - lot_rd.cost : lot_rd.cost - unit_ff;
      end
      if (cmd.lot_add) begin
         realized_in = sum_lot;
         rem_in      = rem_ff - closed_ff;
         if (closed_ff == lot_ff.shares) begin
            popped_in = popped_ff + CW'(1);
         end else begin
            partial_in = 1'b1;
            left_in    = lot_ff.shares - closed_ff;
         end
      end
      if (cmd.commit) begin
         head_in  = wrap_idx((CW + 1)'(head_ff) + (CW + 1)'(popped_ff));
         count_in = count_ff - popped_ff;
         pos_in   = npos_ff;
         cash_in  = ncash_ff;
         feet_in  = nfee_ff;
         rebt_in  = nreb_ff;
         realt_in = sum_real;
         vol_in   = sum_vol[63:0];
         wr_en    = partial_ff;
      end
      if (cmd.push) begin
         wr_en    = 1'b1;
         wr_addr  = wrap_idx((CW + 1)'(head_ff) + (CW + 1)'(count_ff));
         wr_lot   = {sell_ff, rem_ff, unit_ff};
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tv_in     = rsp_tv_ff;
      rsp_fe_in     = rsp_fe_ff;
      rsp_rb_in     = rsp_rb_ff;
      rsp_rz_in     = rsp_rz_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.out_status;
         if (cmd.out_status == flpl_pkg::STAT_OK) begin
            rsp_tv_in = tv_ff[62:0];
            rsp_fe_in = fe_ff[62:0];
            rsp_rb_in = rb_ff[62:0];
            rsp_rz_in = realized_ff;
         end else begin
            rsp_tv_in = '0;
            rsp_fe_in = '0;
            rsp_rb_in = '0;
            rsp_rz_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts.qty_zero  = (qty_ff == '0);
      sts.mul_ovf   = (full_ff > {32'd0, lim});
      sts.sums_ovf  = add_ovf(pos_ff, sq, sum_pos) | add_ovf(cash_ff, cash_add, sum_cash) |
                      add_ovf(feet_ff, fe_ff, sum_fee) | add_ovf(rebt_ff, rb_ff, sum_reb) |
                      sum_vol[64];
      sts.walk_done = (rem_ff == '0) || (popped_ff == count_ff);
      sts.same_side = (lot_rd.is_sell == sell_ff);
      sts.lot_ovf   = add_ovf(realized_ff, piece_ff, sum_lot);
      sts.ring_full = (rem_ff != '0) && ((count_ff - popped_ff) >= CNT_DEPTH);
      sts.real_ovf  = add_ovf(realt_ff, realized_ff, sum_real);
      sts.rem_zero  = (rem_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   flpl_ram #(
      .WIDTH ($bits(flpl_pkg::lot_type)),
      .DEPTH (LOT_DEPTH)
   ) u_lot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_lot),
      .rd_en   (cmd.lot_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_notional_value  = rsp_tv_ff;
   assign rsp_fee_amount      = rsp_fe_ff;
   assign rsp_rebate_amount   = rsp_rb_ff;
   assign rsp_realized_change = rsp_rz_ff;
endmodule

>>> rtl/fifo_lot_position_ledger.sv
// ----------------------------------------------------------------------------
// fifo_lot_position_ledger
// Takes one fill word (side, quantity, price), updates the position, cash,
// fee, rebate, realized and volume totals, closes opposite-side lots oldest
// first from the lot ring and pushes any remainder as a new lot. A rejected
// fill (zero quantity, overflow, full ring) leaves all state untouched and
// returns a status with zero values. One fill is worked at a time; an accepted
// fill takes longer for each lot closed, when a lot is pushed and when the walk
// stops at a same-side lot; rejected fills end earlier. The time is set by the
// shared 64x32 multiplier (each product passes load, low half, high half, sum
// and finish steps; four products per fill and one per closed lot) and the
// one-read lot RAM. The result word sits in an output register, so the next
// fill is taken while it waits.
// ----------------------------------------------------------------------------
module fifo_lot_position_ledger #(
   parameter int LOT_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   flpl_req_if.sink          req_if,
   flpl_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [29:0]       csr_wdata
);
   flpl_pkg::dp_cmd_type cmd;
   flpl_pkg::dp_sts_type sts;

   flpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   flpl_dpath #(
      .LOT_DEPTH (LOT_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_side            (req_if.side),
      .req_quantity        (req_if.fill_quantity),
      .req_price           (req_if.fill_price),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_status          (rsp_if.status),
      .rsp_notional_value  (rsp_if.notional_value),
      .rsp_fee_amount      (rsp_if.fee_amount),
      .rsp_rebate_amount   (rsp_if.rebate_amount),
      .rsp_realized_change (rsp_if.realized_change)
   );
endmodule

>>> rtl/flpl_checker.sv
// ----------------------------------------------------------------------------
// flpl_checker
// Port-level checks of the ledger, bound to the top level.
// ----------------------------------------------------------------------------
module flpl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [62:0] rsp_notional_value,
   input logic [62:0] rsp_fee_amount,
   input logic [62:0] rsp_rebate_amount,
   input logic [63:0] rsp_realized_change
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != flpl_pkg::STAT_OK) |->
      (rsp_notional_value == '0) && (rsp_fee_amount == '0) &&
      (rsp_rebate_amount == '0) && (rsp_realized_change == '0))
      else $error("rejected fill carries nonzero values");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("fill accepted on consecutive cycles");
endmodule

bind fifo_lot_position_ledger flpl_checker u_flpl_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_status          (rsp_if.status),
   .rsp_notional_value  (rsp_if.notional_value),
   .rsp_fee_amount      (rsp_if.fee_amount),
   .rsp_rebate_amount   (rsp_if.rebate_amount),
   .rsp_realized_change (rsp_if.realized_change)
);

>>> tb/flpl_ledger_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flpl_ledger_checker
// Watches the fill, result and register ports of the lot position ledger and
// keeps its own copy of the ledger: totals, the lot ring and the three
// registers. Each accepted fill word is booked into that copy, and the result
// word it should produce is queued. Each accepted result word is compared
// field by field with the oldest queued one. The fail count and the number of
// results still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module flpl_ledger_checker (
   input  logic        clock,
   input  logic        reset,
   flpl_req_if         req,
   flpl_rsp_if         rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [29:0] csr_wdata,
   output int          fail_count,
   output int          owed_results,
   output int          fills_seen,
   output int          ok_fills,
   output int          rejected_fills
);

   localparam int RING = 64;

   typedef struct {
      flpl_pkg::status_type status;
      logic [62:0]          notional_value;
      logic [62:0]          fee_amount;
      logic [62:0]          rebate_amount;
      logic signed [63:0]   realized_change;
   } fill_result_type;

   logic [29:0]        unit_scale, fee_rate, rebate_rate;
   logic               lot_sell [RING];
   logic [31:0]        lot_qty  [RING];
   logic signed [63:0] lot_unit [RING];
   int                 head, count;
   logic signed [63:0] position, cash_sum, fee_sum, rebate_sum, realized_sum;
   logic [63:0]        volume_sum;

   fill_result_type expected_results[$];
   int              err_count, n_in, n_out, n_ok, n_rej;

   assign fail_count     = err_count;
   assign owed_results   = n_in - n_out;
   assign fills_seen     = n_in;
   assign ok_fills       = n_ok;
   assign rejected_fills = n_rej;

   function automatic bit mul_fits(logic signed [63:0] v, logic [63:0] q,
                                   output logic signed [63:0] r);
      logic signed [128:0] p;
      p = $signed({{65{v[63]}}, v}) * $signed({65'b0, q});
      r = p[63:0];
      return (p[128:63] == '0) || (p[128:63] == '1);
   endfunction

   function automatic bit add_fits(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic signed [63:0] r);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      r = s[63:0];
      return s[64] == s[63];
   endfunction

   function automatic fill_result_type book_fill(logic sell, logic [31:0] qty,
                                                 logic [31:0] price);
      fill_result_type    r;
      logic signed [63:0] unit, tv, fe, rb, npos, ncash, nfee, nreb, nreal;
      logic signed [63:0] realized, per, piece;
      logic [63:0]        rem, have, closed;
      logic [64:0]        vol;
      logic [31:0]        left;
      bit                 partial;
      int                 popped, idx;
      r = '{flpl_pkg::STAT_OK, '0, '0, '0, '0};
      realized = '0;
      partial = 0;
      popped = 0;
      left = '0;
      if (qty == '0) begin
         r.status = flpl_pkg::STAT_BADQTY;
         return r;
      end
      if (!mul_fits({34'b0, unit_scale}, {32'b0, price}, unit) ||
          !mul_fits(unit, {32'b0, qty}, tv) ||
          !mul_fits({34'b0, fee_rate}, {32'b0, qty}, fe) ||
          !mul_fits({34'b0, rebate_rate}, {32'b0, qty}, rb)) begin
         r.status = flpl_pkg::STAT_OVF;
         return r;
      end
      vol = {1'b0, volume_sum} + {33'b0, qty};
      if (!add_fits(position, sell ? -$signed({32'b0, qty}) : $signed({32'b0, qty}),
                    npos) ||
          !add_fits(cash_sum, sell ? tv : -tv, ncash) ||
          !add_fits(fee_sum, fe, nfee) ||
          !add_fits(rebate_sum, rb, nreb) || vol[64]) begin
         r.status = flpl_pkg::STAT_OVF;
         return r;
      end
      rem = {32'b0, qty};
      while (rem != '0 && popped < count) begin
         idx = (head + popped) % RING;
         if (lot_sell[idx] == sell) break;
         have = {32'b0, lot_qty[idx]};
         closed = rem < have ? rem : have;
         per = sell ? unit - lot_unit[idx] : lot_unit[idx] - unit;
         if (!mul_fits(per, closed, piece) || !add_fits(realized, piece, realized)) begin
            r.status = flpl_pkg::STAT_OVF;
            return r;
         end
         rem -= closed;
         if (closed == have) popped++;
         else begin
            partial = 1;
            left = 32'(have - closed);
         end
      end
      if (rem != '0 && count - popped >= RING) begin
         r.status = flpl_pkg::STAT_FULL;
         return r;
      end
      if (!add_fits(realized_sum, realized, nreal)) begin
         r.status = flpl_pkg::STAT_OVF;
         return r;
      end
      head = (head + popped) % RING;
      count -= popped;
      if (partial) lot_qty[head] = left;
      if (rem != '0) begin
         idx = (head + count) % RING;
         lot_sell[idx] = sell;
         lot_qty[idx] = rem[31:0];
         lot_unit[idx] = unit;
         count++;
      end
      position = npos;
      cash_sum = ncash;
      fee_sum = nfee;
      rebate_sum = nreb;
      realized_sum = nreal;
      volume_sum = vol[63:0];
      r.notional_value = tv[62:0];
      r.fee_amount = fe[62:0];
      r.rebate_amount = rb[62:0];
      r.realized_change = realized;
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      err_count++;
   endtask

   initial err_count = 0;

   always @(posedge clock) begin
      fill_result_type e;
      if (reset) begin
         unit_scale <= flpl_pkg::PRICE_SCALE_RESET;
         fee_rate <= '0;
         rebate_rate <= '0;
         head = 0;
         count = 0;
         position = '0;
         cash_sum = '0;
         fee_sum = '0;
         rebate_sum = '0;
         realized_sum = '0;
         volume_sum = '0;
         expected_results.delete();
         n_in <= 0;
         n_out <= 0;
         n_ok <= 0;
         n_rej <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               flpl_pkg::CSR_PRICE_SCALE:      unit_scale <= csr_wdata;
               flpl_pkg::CSR_FEE_PER_SHARE:    fee_rate <= csr_wdata;
               flpl_pkg::CSR_REBATE_PER_SHARE: rebate_rate <= csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            e = book_fill(req.side, req.fill_quantity, req.fill_price);
            expected_results.insert(expected_results.size(), e);
            n_in <= n_in + 1;
            if (e.status == flpl_pkg::STAT_OK) n_ok <= n_ok + 1;
            else n_rej <= n_rej + 1;
         end
         if (rsp.valid && rsp.ready) begin
            n_out <= n_out + 1;
            if (expected_results.size() == 0) begin
               report("unexpected result word", {62'b0, rsp.status}, '0);
            end else begin
               e = expected_results[0];
               expected_results.delete(0);
               if (rsp.status !== e.status)
                  report("status", {62'b0, rsp.status}, {62'b0, e.status});
               if (rsp.notional_value !== e.notional_value)
                  report("notional_value", {1'b0, rsp.notional_value},
                         {1'b0, e.notional_value});
               if (rsp.fee_amount !== e.fee_amount)
                  report("fee_amount", {1'b0, rsp.fee_amount}, {1'b0, e.fee_amount});
               if (rsp.rebate_amount !== e.rebate_amount)
                  report("rebate_amount", {1'b0, rsp.rebate_amount},
                         {1'b0, e.rebate_amount});
               if (rsp.realized_change !== e.realized_change)
                  report("realized_change", rsp.realized_change, e.realized_change);
            end
         end
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the lot position ledger. A short directed set hits
// zero quantity, overflow, zero price, partial and full lot closes; then
// random phases under several register settings run trends that fill the lot
// ring, mixed-side trading and full-range noise, with random gaps on both
// channels, one long result hold-off and drain pauses between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int FILLS = 1150;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [29:0] csr_wdata;
   int          fail_count, owed_results, fills_seen, ok_fills, rejected_fills;
   int          sent;
   bit          calm, hold_go, hold_done;

   flpl_req_if req_if ();
   flpl_rsp_if rsp_if ();

   fifo_lot_position_ledger dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   flpl_ledger_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .owed_results   (owed_results),
      .fills_seen     (fills_seen),
      .ok_fills       (ok_fills),
      .rejected_fills (rejected_fills)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("fifo_lot_position_ledger test failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
            hold_done = 1;
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 27);
      end
   end

   task automatic send_fill(logic sell, logic [31:0] qty, logic [31:0] price);
      if (!calm && $urandom_range(99) < 27) begin
         req_if.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 27);
      end
      req_if.valid <= 1;
      req_if.side <= sell;
      req_if.fill_quantity <= qty;
      req_if.fill_price <= price;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (owed_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(flpl_pkg::csr_index_type idx, logic [29:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int          run, k, kind;
      logic        sell;
      logic [31:0] base;
      while (n > 0) begin
         kind = $urandom_range(99);
         run = $urandom_range(1, 80);
         sell = 1'($urandom_range(1));
         base = $urandom_range(100, 20000);
         for (k = 0; k < run && n > 0; k++, n--) begin
            if (kind < 55)
               send_fill($urandom_range(99) < 90 ? sell : ~sell, $urandom_range(1, 2000),
                         base + $urandom_range(0, 400));
            else if (kind < 85)
               send_fill(1'($urandom_range(1)), $urandom_range(1, 5000),
                         $urandom_range(100, 20000));
            else
               send_fill(1'($urandom_range(1)), $urandom(),
                         $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 3000));
         end
      end
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = flpl_pkg::CSR_PRICE_SCALE;
      csr_wdata = '0;
      req_if.valid = 0;
      req_if.side = 0;
      req_if.fill_quantity = '0;
      req_if.fill_price = '0;
      sent = 0;
      calm = 0;
      hold_go = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_fill(1'b0, 0, 1000);
      send_fill(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fill(1'b0, 10, 1000);
      send_fill(1'b0, 5, 1200);
      send_fill(1'b1, 4, 1500);
      send_fill(1'b1, 20, 900);
      send_fill(1'b0, 1, 0);
      send_fill(1'b1, 30, 32'hFFFF_FFFF);
      send_fill(1'b0, 32'hFFFF_FFFF, 1);
      send_fill(1'b0, 32'h8000_0000, 32'h0001_0000);
      send_fill(1'b1, 1, 1);
      drain();
      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'd0);
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'd1000000000);
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'd1000000000);
      send_fill(1'b0, 7, 500);
      send_fill(1'b1, 32'hFFFF_FFFF, 200);
      send_fill(1'b1, 9, 32'hFFFF_FFFF);
      drain();

      calm = 1;
      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'd1);
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'd0);
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'd0);
      random_phase(230);
      calm = 0;
      drain();

      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'd1000000000);
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'd3);
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'd1);
      hold_go = 1;
      random_phase(230);
      drain();

      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'd100000);
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'($urandom_range(0, 50000)));
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'($urandom_range(0, 50000)));
      random_phase(230);
      drain();

      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'($urandom_range(1, 1000000000)));
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'($urandom_range(0, 1000000000)));
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'($urandom_range(0, 1000000000)));
      random_phase(FILLS - sent > 0 ? (FILLS - sent) / 2 : 1);
      drain();

      write_reg(flpl_pkg::CSR_PRICE_SCALE, 30'd100000);
      write_reg(flpl_pkg::CSR_FEE_PER_SHARE, 30'd0);
      write_reg(flpl_pkg::CSR_REBATE_PER_SHARE, 30'd0);
      random_phase(FILLS - sent > 0 ? FILLS - sent : 1);
      drain();
      repeat (40) @(posedge clock);

      $display("Booked %0d fills over seven register settings: %0d accepted, %0d rejected.",
               fills_seen, ok_fills, rejected_fills);
      if (fail_count == 0) $display("fifo_lot_position_ledger test passed");
      else $display("fifo_lot_position_ledger test failed");
      $finish;
   end

endmodule
